>>> src/assert_macros.svh
// Assertion helpers used by resp_packet_value_parser.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define RPVP_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define RPVP_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

`else

`define RPVP_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define RPVP_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg)

`endif

`endif

>>> src/rpvp_pkg.sv
package rpvp_pkg;

    localparam int QueueDepth = 4;

    localparam logic [3:0][7:0] MagicTag = {8'h50, 8'h53, 8'h45, 8'h52};

    localparam logic [2:0] HeaderLast = 3'd5;
    localparam logic [2:0] TagBytes   = 3'd4;

    localparam logic [1:0] KIND_VALUE  = 2'd0;
    localparam logic [1:0] KIND_MARKER = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_ZERO_COUNT = 2'd2;
    localparam logic [1:0] ST_TRUNCATED  = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_COUNT  = 3'd1,
        PH_WORD   = 3'd2,
        PH_DONE   = 3'd3,
        PH_SKIP   = 3'd4
    } phase_t;

    typedef struct packed {
        logic        main_valid;
        logic        main_marker;
        logic [31:0] value_bits;
        logic [7:0]  group_number;
        logic [7:0]  value_number;
        logic        status_valid;
        logic [1:0]  packet_status;
    } entry_t;

endpackage

>>> src/rpvp_if.sv
interface rpvp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rpvp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [31:0] value_bits;
    logic [7:0]  group_number;
    logic [7:0]  value_number;
    logic [1:0]  packet_status;
    logic        run_end;

    modport source (output valid, output result_kind, output value_bits,
                    output group_number, output value_number,
                    output packet_status, output run_end, input ready);
    modport sink   (input valid, input result_kind, input value_bits,
                    input group_number, input value_number,
                    input packet_status, input run_end, output ready);
endinterface

>>> src/rpvp_front.sv
module rpvp_front (
    input  logic            clk,
    input  logic            rst_n,
    rpvp_byte_if.sink       byte_in,
    input  logic            q_ready,
    output logic            push_valid,
    output rpvp_pkg::entry_t push_entry
);
    import rpvp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  gt_reg, gt_next;
    logic [7:0]  gc_reg, gc_next;
    logic [7:0]  vl_reg, vl_next;
    logic [7:0]  vc_reg, vc_next;
    logic [1:0]  wb_reg, wb_next;
    logic [23:0] wa_reg, wa_next;
    logic [1:0]  err_reg, err_next;

    logic [7:0] b;
    logic [7:0] gc_inc;
    logic [7:0] vl_dec;
    logic       accept;
    entry_t     entry;

    assign b       = byte_in.data_byte;
    assign gc_inc  = gc_reg + 8'd1;
    assign vl_dec  = vl_reg - 8'd1;
    assign accept  = byte_in.valid && byte_in.ready;
    assign byte_in.ready = q_ready;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        gt_next    = gt_reg;
        gc_next    = gc_reg;
        vl_next    = vl_reg;
        vc_next    = vc_reg;
        wb_next    = wb_reg;
        wa_next    = wa_reg;
        err_next   = err_reg;
        entry      = '0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (pos_reg < TagBytes && b != MagicTag[pos_reg[1:0]] && err_reg == ST_OK)
                begin
                    err_next = ST_BAD_HEADER;
                end
                if (pos_reg >= HeaderLast)
                begin
                    if (err_reg != ST_OK)
                    begin
                        phase_next = PH_SKIP;
                    end
                    else if (b == 8'd0)
                    begin
                        err_next   = ST_ZERO_COUNT;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        gt_next    = b;
                        gc_next    = 8'd0;
                        phase_next = PH_COUNT;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 3'd1;
                end
            end
            PH_COUNT:
            begin
                vl_next = b;
                vc_next = 8'd0;
                wb_next = 2'd0;
                wa_next = 24'd0;
                if (b == 8'd0)
                begin
                    entry.main_valid   = 1'b1;
                    entry.main_marker  = 1'b1;
                    entry.group_number = gc_reg;
                    gc_next    = gc_inc;
                    phase_next = (gc_inc == gt_reg) ? PH_DONE : PH_COUNT;
                end
                else
                begin
                    phase_next = PH_WORD;
                end
            end
            PH_WORD:
            begin
                if (wb_reg != 2'd3)
                begin
                    unique case (wb_reg)
                        2'd0:    wa_next[7:0]   = b;
                        2'd1:    wa_next[15:8]  = b;
                        default: wa_next[23:16] = b;
                    endcase
                    wb_next = wb_reg + 2'd1;
                end
                else
                begin
                    entry.main_valid   = 1'b1;
                    entry.value_bits   = {b, wa_reg};
                    entry.group_number = gc_reg;
                    entry.value_number = vc_reg;
                    wa_next = 24'd0;
                    wb_next = 2'd0;
                    vc_next = vc_reg + 8'd1;
                    vl_next = vl_dec;
                    if (vl_dec == 8'd0)
                    begin
                        gc_next    = gc_inc;
                        phase_next = (gc_inc == gt_reg) ? PH_DONE : PH_COUNT;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (byte_in.last_byte)
        begin
            entry.status_valid = 1'b1;
            priority if (err_next != ST_OK)
                entry.packet_status = err_next;
            else if (phase_next == PH_HEADER)
                entry.packet_status = ST_BAD_HEADER;
            else if (phase_next == PH_DONE)
                entry.packet_status = ST_OK;
            else
                entry.packet_status = ST_TRUNCATED;
            phase_next = PH_HEADER;
            pos_next   = 3'd0;
            gt_next    = 8'd0;
            gc_next    = 8'd0;
            vl_next    = 8'd0;
            vc_next    = 8'd0;
            wb_next    = 2'd0;
            wa_next    = 24'd0;
            err_next   = ST_OK;
        end
    end

    assign push_valid = accept && (entry.main_valid || entry.status_valid);
    assign push_entry = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= 3'd0;
            gt_reg    <= 8'd0;
            gc_reg    <= 8'd0;
            vl_reg    <= 8'd0;
            vc_reg    <= 8'd0;
            wb_reg    <= 2'd0;
            wa_reg    <= 24'd0;
            err_reg   <= ST_OK;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            gt_reg    <= gt_next;
            gc_reg    <= gc_next;
            vl_reg    <= vl_next;
            vc_reg    <= vc_next;
            wb_reg    <= wb_next;
            wa_reg    <= wa_next;
            err_reg   <= err_next;
        end
    end

endmodule

>>> src/rpvp_queue.sv
module rpvp_queue #(
    parameter int DEPTH = rpvp_pkg::QueueDepth
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push_valid,
    input  rpvp_pkg::entry_t               push_entry,
    output logic                           not_full,
    input  logic                           pop,
    output logic                           head_valid,
    output rpvp_pkg::entry_t               head_entry,
    output logic [$clog2(DEPTH + 1) - 1:0] count
);
    import rpvp_pkg::*;

    localparam int PtrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CountW = $clog2(DEPTH + 1);

    entry_t            mem_reg [DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CountW-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign not_full   = count_reg != CountW'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_entry = mem_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_push    = push_valid && not_full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CountW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CountW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/rpvp_back.sv
module rpvp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  rpvp_pkg::entry_t head_entry,
    output logic             pop,
    rpvp_result_if.source    result_out
);
    import rpvp_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic        half_reg, half_next;
    logic [1:0]  kind_reg;
    logic [31:0] bits_reg;
    logic [7:0]  grp_reg;
    logic [7:0]  val_reg;
    logic [1:0]  st_reg;
    logic        run_end_reg;

    logic        load;
    logic        main_part;
    logic        last_part;

    assign load      = head_valid && (!out_valid_reg || result_out.ready);
    assign main_part = head_entry.main_valid && !half_reg;
    assign last_part = !main_part || !head_entry.status_valid;
    assign pop       = load && last_part;

    always_comb
    begin
        half_next      = half_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            half_next      = !last_part;
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            run_end_reg <= last_part;
            if (main_part)
            begin
                kind_reg <= head_entry.main_marker ? KIND_MARKER : KIND_VALUE;
                bits_reg <= head_entry.value_bits;
                grp_reg  <= head_entry.group_number;
                val_reg  <= head_entry.value_number;
                st_reg   <= ST_OK;
            end
            else
            begin
                kind_reg <= KIND_STATUS;
                bits_reg <= 32'd0;
                grp_reg  <= 8'd0;
                val_reg  <= 8'd0;
                st_reg   <= head_entry.packet_status;
            end
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.result_kind   = kind_reg;
    assign result_out.value_bits    = bits_reg;
    assign result_out.group_number  = grp_reg;
    assign result_out.value_number  = val_reg;
    assign result_out.packet_status = st_reg;
    assign result_out.run_end       = run_end_reg;

endmodule

>>> src/resp_packet_value_parser.sv
// Reply datagram parser: bytes in on byte_in, one transaction per byte,
// last_byte set on the final byte of a datagram. Results out on result_out:
// value words (raw float bits with group and value index), empty group
// markers, and one packet status per datagram on its final byte.
// run_end marks the last result caused by one input byte; a byte causes
// at most two results (a value or marker, then the status).
// A result passes through the queue and then the output register.
// Throughput: one byte per cycle while the queue is not full; the output
// register issues one result per cycle while the receiver is ready, so a
// byte with two results holds it for both. The queue (QUEUE_DEPTH entries)
// stores both results of a byte in one entry, popped after the last.
// Reset clears the parser state, the queue and the output register; the
// next byte is taken as byte 0 of a datagram.
// When the receiver stalls, results wait in the output register and the
// queue; byte_in.ready drops once the queue is full and rises as it drains.
// Consumers discard every result of a datagram whose status is not ok.
`include "assert_macros.svh"

module resp_packet_value_parser #(
    parameter int QUEUE_DEPTH = rpvp_pkg::QueueDepth
) (
    input  logic          clk,
    input  logic          rst_n,
    rpvp_byte_if.sink     byte_in,
    rpvp_result_if.source result_out
);
    import rpvp_pkg::*;

    localparam int CountW = $clog2(QUEUE_DEPTH + 1);

    logic              q_ready;
    logic              push_valid;
    entry_t            push_entry;
    logic              pop;
    logic              head_valid;
    entry_t            head_entry;
    logic [CountW-1:0] q_count;

    rpvp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .q_ready    (q_ready),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    rpvp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .not_full   (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .count      (q_count)
    );

    rpvp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .result_out (result_out)
    );

    `RPVP_ASSERT(a_status_follows, clk, rst_n,
        result_out.valid && result_out.ready && !result_out.run_end |=>
            result_out.valid && result_out.result_kind == KIND_STATUS,
        "status does not follow a non-final result")
    `RPVP_ASSERT(a_count_bound, clk, rst_n, q_count <= CountW'(QUEUE_DEPTH),
        "queue count exceeds depth")
    `RPVP_ASSERT(a_ready_full, clk, rst_n,
        byte_in.ready == (q_count != CountW'(QUEUE_DEPTH)),
        "input ready disagrees with queue fill")
    `RPVP_ASSERT_IMPL(a_status_shape, clk, rst_n,
        result_out.valid && result_out.result_kind == KIND_STATUS,
        result_out.run_end && result_out.value_bits == 32'd0,
        "status transaction malformed")

endmodule
